// File: design/huffman_escape_bit_packer_defines.svh
// Assertion helpers used by the top-level packer's self-checks.
`ifndef HUFFMAN_ESCAPE_BIT_PACKER_DEFINES_SVH
`define HUFFMAN_ESCAPE_BIT_PACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HEBP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hebp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HEBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hebp assertion failed");

`endif

// File: design/hebp_pkg.sv
`timescale 1ns / 1ps
package hebp_pkg;

	localparam int CODED_ENTRIES = 10;
	localparam int MAX_CODE_LEN  = 16;
	localparam int PAIR_REGS     = (CODED_ENTRIES + 1) / 2;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_W         = 58;
	localparam int ENTRY_W       = 29;
	localparam int CODE_W        = 16;
	localparam int LEN_W         = 5;
	localparam int RAW_LEN       = 8;
	localparam int ESC_LEN       = 10;
	localparam int PART_W        = 7;
	localparam int FILL_W        = 3;
	localparam int ACC_W         = PART_W + CODE_W;
	localparam int FIFO_DEPTH    = 4;
	localparam int FIFO_PTR_W    = 2;
	localparam int FIFO_CNT_W    = 3;

	localparam logic [1:0] ESC_PREFIX = 2'b10;

	typedef enum logic {
		KIND_ENCODE = 1'b0,
		KIND_FLUSH  = 1'b1
	} kind_t;

	typedef struct packed {
		logic [7:0]       sym;
		logic [LEN_W-1:0] len;
		logic [CODE_W-1:0] code;
	} entry_t;

	typedef struct packed {
		logic [CODE_W-1:0] bits;
		logic [LEN_W-1:0]  len;
	} code_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} beat_t;

	typedef struct packed {
		logic [1:0] n;
		beat_t      b0;
		beat_t      b1;
	} push_t;

	typedef struct packed {
		logic              fire;
		logic              flush;
		logic [FILL_W-1:0] fill;
	} pk_status_t;

	typedef struct packed {
		logic [FIFO_CNT_W-1:0] count;
		logic                  pop;
	} fifo_status_t;

endpackage

// File: design/hebp_channels.sv
`timescale 1ns / 1ps
interface hebp_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] in_byte;

	modport source (output valid, output kind, output in_byte, input ready);
	modport sink   (input valid, input kind, input in_byte, output ready);
endinterface

interface hebp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;

	modport source (output valid, output out_byte, output last, input ready);
	modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// File: design/huffman_escape_bit_packer.sv
`timescale 1ns / 1ps
// Byte-in, byte-out Huffman packer with an escape code. Each encode beat is
// matched against ten table entries (symbol, length 1..16, code) held in five
// 58-bit pair registers; the first valid hit appends its code, a miss appends
// 10 followed by the raw byte. Bits leave MSB first as whole bytes; a flush
// beat pads the pending partial byte with zeros and sends it with last set
// (nothing is sent if no bits are pending). An input beat is registered, then
// matched and packed combinationally into a four-beat output queue; a new beat is
// taken every cycle while the queue has room for two bytes. One item yields up
// to two output bytes and the output port moves one byte a cycle while the sink
// is ready, so the sustained rate is one item per cycle for short codes and
// falls when every item completes two bytes. Write the table only while the
// block is idle.
`include "huffman_escape_bit_packer_defines.svh"
module huffman_escape_bit_packer
	import hebp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	hebp_in_if.sink              in_ch,
	hebp_out_if.source           out_ch,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	logic [CFG_W-1:0] cfg_q [PAIR_REGS];
	entry_t           entries [CODED_ENTRIES];

	logic       valid_s1;
	logic       kind_s1;
	logic [7:0] byte_s1;

	code_t        cw;
	push_t        push;
	pk_status_t   pk_st;
	fifo_status_t fifo_st;
	beat_t        head;
	logic         pop;
	logic         room;
	logic         fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PAIR_REGS; i++)
				cfg_q[i] <= '0;
		end else if (cfg_wr_en && cfg_index < CFG_IDX_W'(PAIR_REGS)) begin
			cfg_q[cfg_index] <= cfg_wdata;
		end
	end

	// Even entry in the low half of a pair register, odd entry above it.
	always_comb begin
		for (int i = 0; i < CODED_ENTRIES; i++)
			entries[i] = entry_t'(cfg_q[i >> 1][(i % 2) * ENTRY_W +: ENTRY_W]);
	end

	assign pop  = out_ch.valid && out_ch.ready;
	assign room = (fifo_st.count <= FIFO_CNT_W'(FIFO_DEPTH - 2))
		|| (pop && fifo_st.count == FIFO_CNT_W'(FIFO_DEPTH - 1));
	assign fire = valid_s1 && room;

	assign in_ch.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			kind_s1 <= in_ch.kind;
			byte_s1 <= in_ch.in_byte;
		end
	end

	hebp_match u_match (
		.entries (entries),
		.in_byte (byte_s1),
		.cw      (cw)
	);

	hebp_packer u_packer (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.kind   (kind_s1),
		.cw     (cw),
		.push   (push),
		.st     (pk_st)
	);

	hebp_out_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.st     (fifo_st)
	);

	assign out_ch.valid    = (fifo_st.count != '0);
	assign out_ch.out_byte = head.data;
	assign out_ch.last     = head.last;

	// queue never overfills when the packer writes one or two bytes
	`HEBP_ASSERT_NOW(a_no_overflow, clk, arst_n, push.n != 2'd0, fifo_st.count - FIFO_CNT_W'(fifo_st.pop) + FIFO_CNT_W'(push.n) <= FIFO_CNT_W'(FIFO_DEPTH))
	// flush with nothing pending sends no beat
	`HEBP_ASSERT_NOW(a_empty_flush, clk, arst_n, pk_st.fire && pk_st.flush && pk_st.fill == '0, push.n == 2'd0)
	// a flush always leaves the packer empty
	`HEBP_ASSERT_NEXT(a_flush_clears, clk, arst_n, pk_st.fire && pk_st.flush, pk_st.fill == '0)

endmodule

// File: design/hebp_match.sv
`timescale 1ns / 1ps
module hebp_match
	import hebp_pkg::*;
(
	input  entry_t     entries [CODED_ENTRIES],
	input  logic [7:0] in_byte,
	output code_t      cw
);

	logic [CODE_W:0] mask;

	// Walk from the top so the lowest numbered valid hit wins.
	always_comb begin
		cw.bits = {{(CODE_W-ESC_LEN){1'b0}}, ESC_PREFIX, in_byte};
		cw.len  = LEN_W'(ESC_LEN);
		mask    = '0;
		for (int i = CODED_ENTRIES - 1; i >= 0; i--) begin
			if (entries[i].len != '0 && entries[i].len <= LEN_W'(MAX_CODE_LEN)
					&& entries[i].sym == in_byte) begin
				mask    = ({{CODE_W{1'b0}}, 1'b1} << entries[i].len) - 1'b1;
				cw.bits = entries[i].code & mask[CODE_W-1:0];
				cw.len  = entries[i].len;
			end
		end
	end

endmodule

// File: design/hebp_packer.sv
`timescale 1ns / 1ps
module hebp_packer
	import hebp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic       kind,
	input  code_t      cw,
	output push_t      push,
	output pk_status_t st
);

	logic [PART_W-1:0] partial_q;
	logic [FILL_W-1:0] fill_q;

	logic [ACC_W-1:0]  acc;
	logic [LEN_W-1:0]  total;
	logic [LEN_W-1:0]  sh0;
	logic [LEN_W-1:0]  sh1;
	logic [FILL_W-1:0] rem;
	logic [PART_W-1:0] rem_mask;
	logic [14:0]       flush_word;
	logic [PART_W-1:0] partial_d;
	logic [FILL_W-1:0] fill_d;

	always_comb begin
		acc        = ({{CODE_W{1'b0}}, partial_q} << cw.len) | {{PART_W{1'b0}}, cw.bits};
		total      = LEN_W'(fill_q) + cw.len;
		sh0        = total - LEN_W'(8);
		sh1        = total - LEN_W'(16);
		rem        = total[FILL_W-1:0];
		rem_mask   = ~({PART_W{1'b1}} << rem);
		flush_word = {8'b0, partial_q} << (4'd8 - {1'b0, fill_q});

		push.b0.data = 8'(acc >> sh0);
		push.b0.last = 1'b0;
		push.b1.data = 8'(acc >> sh1);
		push.b1.last = 1'b0;

		if (kind == KIND_FLUSH) begin
			push.n       = (fill_q != '0) ? 2'd1 : 2'd0;
			push.b0.data = flush_word[7:0];
			push.b0.last = 1'b1;
			partial_d    = '0;
			fill_d       = '0;
		end else begin
			if (total >= LEN_W'(16))
				push.n = 2'd2;
			else if (total >= LEN_W'(8))
				push.n = 2'd1;
			else
				push.n = 2'd0;
			partial_d = acc[PART_W-1:0] & rem_mask;
			fill_d    = rem;
		end

		if (!fire)
			push.n = 2'd0;

		st.fire  = fire;
		st.flush = (kind == KIND_FLUSH);
		st.fill  = fill_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			fill_q    <= '0;
		end else if (fire) begin
			partial_q <= partial_d;
			fill_q    <= fill_d;
		end
	end

endmodule

// File: design/hebp_out_fifo.sv
`timescale 1ns / 1ps
module hebp_out_fifo
	import hebp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  push_t        push,
	input  logic         pop,
	output beat_t        head,
	output fifo_status_t st
);

	beat_t                 mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wptr_q;
	logic [FIFO_PTR_W-1:0] rptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	assign head     = mem_q[rptr_q];
	assign st.count = count_q;
	assign st.pop   = pop;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0)
			mem_q[wptr_q] <= push.b0;
		if (push.n == 2'd2)
			mem_q[wptr_q + 1'b1] <= push.b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_q + FIFO_PTR_W'(push.n);
			if (pop)
				rptr_q <= rptr_q + 1'b1;
			count_q <= count_q + FIFO_CNT_W'(push.n) - FIFO_CNT_W'(pop);
		end
	end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import hebp_pkg::*;

	localparam int REG_PAIR_A      = 0;
	localparam int REG_PAIR_E      = 4;
	localparam int CFG_IDX_LAST    = (1 << CFG_IDX_W) - 1;
	localparam int STALL_LIMIT     = 4000;
	localparam int DRAIN_CYCLES    = 8;
	localparam int ITEMS_PER_TABLE = 85;

	typedef enum int {
		TBL_RANDOM,
		TBL_ALL_ONES,
		TBL_FULL_LENGTH,
		TBL_CLEAR
	} table_kind_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	hebp_in_if  in_ch();
	hebp_out_if out_ch();

	huffman_escape_bit_packer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// shadow of the table and the packer state
	logic [CFG_W-1:0]  pair_shadow [PAIR_REGS];
	entry_t            staged [CODED_ENTRIES];
	logic [PART_W-1:0] pend_bits;
	logic [FILL_W-1:0] pend_cnt;
	beat_t             packed_bytes_q [$];
	beat_t             want;

	int unsigned src_idle_pct;
	int unsigned snk_idle_pct;
	int unsigned items_sent;
	int unsigned beats_checked;
	int unsigned tables_loaded;
	int unsigned fail_count;
	int unsigned stall_cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ch.ready <= arst_n && ($urandom_range(99) >= snk_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (packed_bytes_q.size() == 0) begin
				$error("unexpected beat: out_byte %02h last %0b", out_ch.out_byte, out_ch.last);
				fail_count++;
			end else begin
				want = packed_bytes_q.pop_front();
				if (out_ch.out_byte !== want.data) begin
					$error("out_byte: expected %02h, actual %02h", want.data, out_ch.out_byte);
					fail_count++;
				end
				if (out_ch.last !== want.last) begin
					$error("last: expected %0b, actual %0b", want.last, out_ch.last);
					fail_count++;
				end
				beats_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: %0d cycles without a beat", stall_cycles);
			$display("huffman_escape_bit_packer verification failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic entry_t entry_at(int i);
		logic [CFG_W-1:0] w;
		w = pair_shadow[i / 2] >> ((i % 2) * ENTRY_W);
		return entry_t'(w[ENTRY_W-1:0]);
	endfunction

	task automatic predict_packing(input kind_t k, input logic [7:0] b);
		entry_t           ent;
		logic [CODE_W-1:0] bits;
		logic [LEN_W-1:0] len;
		logic [ACC_W-1:0] acc;
		logic [ACC_W-1:0] chunk;
		logic [7:0]       pad;
		int               total;
		bit               hit;
		beat_t            beat;
		if (k == KIND_FLUSH) begin
			// flush with nothing pending emits nothing
			if (pend_cnt != 0) begin
				pad = {1'b0, pend_bits};
				pad = 8'(pad << (8 - pend_cnt));
				beat.data = pad;
				beat.last = 1'b1;
				packed_bytes_q.push_back(beat);
				pend_bits = '0;
				pend_cnt = '0;
			end
			return;
		end
		hit = 1'b0;
		bits = '0;
		len = '0;
		for (int i = 0; i < CODED_ENTRIES; i++) begin
			ent = entry_at(i);
			if (!hit && ent.len != 0 && ent.len <= MAX_CODE_LEN && ent.sym == b) begin
				hit = 1'b1;
				bits = ent.code;
				len = ent.len;
			end
		end
		if (!hit) begin
			bits = {6'b0, ESC_PREFIX, b};
			len = ESC_LEN;
		end
		acc = (ACC_W'(pend_bits) << len) | (ACC_W'(bits) & ((ACC_W'(1) << len) - ACC_W'(1)));
		total = pend_cnt + len;
		while (total >= 8) begin
			chunk = acc >> (total - 8);
			beat.data = chunk[7:0];
			beat.last = 1'b0;
			packed_bytes_q.push_back(beat);
			total -= 8;
		end
		pad = 8'((1 << total) - 1);
		pend_bits = acc[PART_W-1:0] & pad[PART_W-1:0];
		pend_cnt = FILL_W'(total);
	endtask

	task automatic send_item(input kind_t k, input logic [7:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.kind <= k;
		in_ch.in_byte <= b;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		predict_packing(k, b);
		items_sent++;
	endtask

	task automatic send_symbol(input logic [7:0] b);
		send_item(KIND_ENCODE, b);
	endtask

	task automatic send_flush();
		send_item(KIND_FLUSH, 8'($urandom));
	endtask

	// table writes are only made once the packer has gone quiet
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (packed_bytes_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input int idx, input logic [CFG_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx[CFG_IDX_W-1:0];
		cfg_wdata <= data;
		@(posedge clk);
		if (idx < PAIR_REGS)
			pair_shadow[idx] = data;
	endtask

	task automatic load_table(input bit touch_unused);
		for (int p = 0; p < PAIR_REGS; p++)
			write_reg(REG_PAIR_A + p, {staged[2 * p + 1], staged[2 * p]});
		if (touch_unused) begin
			for (int idx = REG_PAIR_E + 1; idx <= CFG_IDX_LAST; idx++)
				write_reg(idx, CFG_W'({$urandom, $urandom}));
		end
		cfg_wr_en <= 1'b0;
		tables_loaded++;
	endtask

	task automatic stage_table(input table_kind_t tkind);
		int r;
		for (int i = 0; i < CODED_ENTRIES; i++) begin
			case (tkind)
				TBL_RANDOM: begin
					r = $urandom_range(99);
					staged[i].sym = (i > 0 && r < 15) ? staged[i - 1].sym : 8'($urandom);
					r = $urandom_range(99);
					if (r < 6)
						staged[i].len = '0;
					else if (r < 12)
						staged[i].len = LEN_W'($urandom_range(31, MAX_CODE_LEN + 1));
					else
						staged[i].len = LEN_W'($urandom_range(MAX_CODE_LEN, 1));
					staged[i].code = CODE_W'($urandom);
				end
				TBL_ALL_ONES: staged[i] = '1;
				TBL_FULL_LENGTH: begin
					staged[i].sym = 8'($urandom);
					staged[i].len = LEN_W'(MAX_CODE_LEN);
					staged[i].code = CODE_W'($urandom);
				end
				default: staged[i] = '0;
			endcase
		end
	endtask

	task automatic send_random_item();
		int     r;
		entry_t ent;
		r = $urandom_range(99);
		ent = entry_at($urandom_range(CODED_ENTRIES - 1));
		if (r < 6)
			send_flush();
		else if (r < 72)
			send_symbol(ent.sym);
		else
			send_symbol(8'($urandom));
	endtask

	// empty table after reset: every byte takes the escape path
	task automatic test_reset_table_escapes();
		send_flush();
		send_symbol(8'h00);
		send_symbol(8'hFF);
		send_symbol(8'h5A);
		send_flush();
		send_flush();
		send_symbol(8'hA5);
		drain();
	endtask

	task automatic test_directed_codes();
		staged[0] = '{sym: 8'h41, len: 5'd1,  code: 16'h0001};
		staged[1] = '{sym: 8'h42, len: 5'd16, code: 16'hBEEF};
		staged[2] = '{sym: 8'h43, len: 5'd17, code: 16'h1234}; // too long, invalid
		staged[3] = '{sym: 8'h44, len: 5'd0,  code: 16'hFFFF}; // zero length, invalid
		staged[4] = '{sym: 8'h41, len: 5'd3,  code: 16'h0002}; // shadowed by entry 0
		staged[5] = '{sym: 8'h45, len: 5'd31, code: 16'h00FF};
		staged[6] = '{sym: 8'h00, len: 5'd8,  code: 16'h00A5};
		staged[7] = '{sym: 8'hFF, len: 5'd16, code: 16'hFFFF};
		staged[8] = '{sym: 8'h46, len: 5'd4,  code: 16'hFFF9}; // upper code bits dropped
		staged[9] = '{sym: 8'h47, len: 5'd7,  code: 16'h0055};
		load_table(1'b1);
		send_flush();
		send_symbol(8'h47);
		send_symbol(8'h42); // seven pending plus sixteen: two bytes at once
		send_symbol(8'h41);
		send_symbol(8'h41);
		send_symbol(8'h43);
		send_symbol(8'h44);
		send_symbol(8'h45);
		send_symbol(8'h46);
		send_symbol(8'h00);
		send_symbol(8'hFF);
		send_flush();
		send_symbol(8'h46);
		send_flush();
		send_flush();
		drain();
	endtask

	task automatic test_random_traffic();
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin src_idle_pct = 35; snk_idle_pct = 45; end
				1: begin src_idle_pct = 45; snk_idle_pct = 35; end
				default: begin src_idle_pct = 0; snk_idle_pct = 0; end
			endcase
			for (int t = TBL_RANDOM; t <= TBL_CLEAR; t++) begin
				stage_table(table_kind_t'(t));
				load_table(t == TBL_CLEAR);
				repeat (ITEMS_PER_TABLE) send_random_item();
				send_flush();
				drain();
			end
		end
	endtask

	task automatic finish_run();
		while (packed_bytes_q.size() != 0)
			@(posedge clk);
		repeat (2 * DRAIN_CYCLES) @(posedge clk);
		$display("%0d items sent, %0d output beats checked, %0d tables loaded",
			items_sent, beats_checked, tables_loaded);
		$display("covered escapes, short and long codes, flushes and three idle patterns");
		if (fail_count == 0)
			$display("huffman_escape_bit_packer verification clean");
		else
			$display("huffman_escape_bit_packer verification failed");
		$finish;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.kind = KIND_ENCODE;
		in_ch.in_byte = '0;
		for (int p = 0; p < PAIR_REGS; p++)
			pair_shadow[p] = '0;
		pend_bits = '0;
		pend_cnt = '0;
		src_idle_pct = 35;
		snk_idle_pct = 45;
		items_sent = 0;
		beats_checked = 0;
		tables_loaded = 0;
		fail_count = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_table_escapes();
		test_directed_codes();
		test_random_traffic();
		finish_run();
	end

endmodule
